// ===== design/rfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_pkg
// shared constants and types for the resyncing frame receiver
// ----------------------------------------------------------------------------
package rfr_pkg;

    localparam int WINDOW_BYTES_DEF = 64;

    // frame layout
    localparam logic [7:0] SYNC_FIRST  = 8'hFE;
    localparam logic [7:0] SYNC_SECOND = 8'hEF;
    localparam logic [7:0] TAIL_FIRST  = 8'h55;
    localparam logic [7:0] TAIL_SECOND = 8'h0D;
    localparam logic [7:0] TAIL_THIRD  = 8'h0A;

    localparam int MIN_TOTAL    = 13;
    localparam int LEN_EXTRA    = 4;
    localparam int LEN_POS      = 3;
    localparam int SUM_START    = 6;
    localparam int MIN_LEN_BYTE = MIN_TOTAL - LEN_EXTRA;
    // offset from the length byte of the last possible start to one past the newest byte
    localparam int SCAN_SPAN    = MIN_TOTAL - LEN_POS;

    typedef enum logic [1:0] {
        ST_FRAME    = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

endpackage

// ===== design/rfr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_ram
// simple dual-port synchronous memory, one write and one registered read port
// ----------------------------------------------------------------------------
module rfr_ram #(
    parameter int DEPTH = rfr_pkg::WINDOW_BYTES_DEF,
    parameter int AW    = $clog2(rfr_pkg::WINDOW_BYTES_DEF)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rfr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_ctrl
// append, scan, checksum and send sequencer around the window memories
// ----------------------------------------------------------------------------
module rfr_ctrl #(
    parameter int WINDOW_BYTES = rfr_pkg::WINDOW_BYTES_DEF,
    parameter int IDX_W        = $clog2(rfr_pkg::WINDOW_BYTES_DEF),
    parameter int CNT_W        = $clog2(rfr_pkg::WINDOW_BYTES_DEF + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       status,
    output logic             last,
    output logic             win_we,
    output logic [IDX_W-1:0] win_waddr,
    output logic [7:0]       win_wdata,
    output logic             win_re,
    output logic [IDX_W-1:0] win_raddr,
    input  logic [7:0]       win_rdata,
    output logic             pp_we,
    output logic [CNT_W-1:0] pp_waddr,
    output logic [7:0]       pp_wdata,
    output logic             pp_re,
    output logic [CNT_W-1:0] pp_raddr,
    input  logic [7:0]       pp_rdata
);

    localparam int SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_CHK_RD,
        S_CHK,
        S_SEND_RD,
        S_SEND_LD,
        S_ERR
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [7:0]            ppr_reg, ppr_next;
    logic [3:0][7:0]       tail_reg, tail_next;
    logic [IDX_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                  arr_valid_reg, arr_valid_next;
    logic [IDX_W-1:0]      arr_idx_reg, arr_idx_next;
    logic [2:0][7:0]       hist_reg, hist_next;
    logic [IDX_W-1:0]      start_reg, start_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      send_idx_reg, send_idx_next;
    rfr_pkg::status_t      err_reg, err_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    rfr_pkg::status_t      out_status_reg, out_status_next;
    logic                  out_last_reg, out_last_next;

    logic                  accept;
    logic                  out_free;
    logic                  scan_issue;
    logic                  tail_ok;
    logic                  min_fill;
    logic                  full;
    logic                  hit;
    logic                  scan_last;
    logic [IDX_W-1:0]      hit_start;
    logic [7:0]            calc;
    logic                  send_last;
    logic [IDX_W-1:0]      send_addr;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // append path
    assign win_we    = accept;
    assign win_waddr = fill_reg[IDX_W-1:0];
    assign win_wdata = rx_byte;
    assign pp_we     = accept;
    assign pp_waddr  = fill_reg + CNT_W'(1);
    assign pp_wdata  = ppr_reg ^ rx_byte;

    assign tail_ok = (tail_reg[2] == rfr_pkg::TAIL_FIRST)
                  && (tail_reg[1] == rfr_pkg::TAIL_SECOND)
                  && (tail_reg[0] == rfr_pkg::TAIL_THIRD);
    assign min_fill = (fill_reg >= CNT_W'(rfr_pkg::MIN_TOTAL));
    assign full     = (fill_reg == CNT_W'(WINDOW_BYTES));

    // streaming scan: one window read per cycle, header checked on arrival
    assign scan_issue = (state_reg == S_SCAN)
        && ((SUM_W'(scan_addr_reg) + SUM_W'(rfr_pkg::SCAN_SPAN)) <= SUM_W'(fill_reg));
    assign hit_start  = arr_idx_reg - IDX_W'(rfr_pkg::LEN_POS);
    assign hit = arr_valid_reg
        && (arr_idx_reg >= IDX_W'(rfr_pkg::LEN_POS))
        && (hist_reg[2] == rfr_pkg::SYNC_FIRST)
        && (hist_reg[1] == rfr_pkg::SYNC_SECOND)
        && (win_rdata >= 8'(rfr_pkg::MIN_LEN_BYTE))
        && ((SUM_W'(win_rdata) + SUM_W'(arr_idx_reg) + SUM_W'(rfr_pkg::LEN_EXTRA))
            == (SUM_W'(fill_reg) + SUM_W'(rfr_pkg::LEN_POS)));
    assign scan_last = arr_valid_reg
        && ((SUM_W'(arr_idx_reg) + SUM_W'(rfr_pkg::SCAN_SPAN)) == SUM_W'(fill_reg));

    // checksum: prefix at the checksum byte minus prefix at the payload start
    assign calc = pp_rdata ^ ppr_reg ^ tail_reg[0] ^ tail_reg[1] ^ tail_reg[2] ^ tail_reg[3];

    assign send_addr = start_reg + send_idx_reg[IDX_W-1:0];
    assign send_last = ((send_idx_reg + CNT_W'(1)) == len_reg);

    assign win_re    = scan_issue || (state_reg == S_SEND_RD);
    assign win_raddr = (state_reg == S_SEND_RD) ? send_addr : scan_addr_reg;
    assign pp_re     = (state_reg == S_CHK_RD);
    assign pp_raddr  = CNT_W'(start_reg) + CNT_W'(rfr_pkg::SUM_START);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        ppr_next        = ppr_reg;
        tail_next       = tail_reg;
        scan_addr_next  = scan_addr_reg;
        arr_valid_next  = 1'b0;
        arr_idx_next    = arr_idx_reg;
        hist_next       = hist_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        send_idx_next   = send_idx_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fill_next  = fill_reg + CNT_W'(1);
                    ppr_next   = ppr_reg ^ rx_byte;
                    tail_next  = {tail_reg[2:0], rx_byte};
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                scan_addr_next = '0;
                if (min_fill && tail_ok)
                begin
                    state_next = S_SCAN;
                end
                else if (full)
                begin
                    err_next   = rfr_pkg::ST_OVERFLOW;
                    state_next = S_ERR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_addr_next = scan_addr_reg + IDX_W'(1);
                    arr_valid_next = 1'b1;
                    arr_idx_next   = scan_addr_reg;
                end
                if (arr_valid_reg)
                begin
                    hist_next = {hist_reg[1:0], win_rdata};
                end
                if (hit)
                begin
                    arr_valid_next = 1'b0;
                    start_next     = hit_start;
                    len_next       = fill_reg - CNT_W'(hit_start);
                    state_next     = S_CHK_RD;
                end
                else if (scan_last)
                begin
                    arr_valid_next = 1'b0;
                    if (full)
                    begin
                        err_next   = rfr_pkg::ST_OVERFLOW;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CHK_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                send_idx_next = '0;
                if (calc == tail_reg[3])
                begin
                    state_next = S_SEND_RD;
                end
                else
                begin
                    err_next   = rfr_pkg::ST_CHECKSUM;
                    state_next = S_ERR;
                end
            end
            S_SEND_RD:
            begin
                state_next = S_SEND_LD;
            end
            S_SEND_LD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = win_rdata;
                    out_status_next = rfr_pkg::ST_FRAME;
                    out_last_next   = send_last;
                    send_idx_next   = send_idx_reg + CNT_W'(1);
                    if (send_last)
                    begin
                        fill_next  = '0;
                        ppr_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SEND_RD;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = '0;
                    out_status_next = err_reg;
                    out_last_next   = 1'b1;
                    fill_next       = '0;
                    ppr_next        = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            ppr_reg        <= '0;
            tail_reg       <= '0;
            scan_addr_reg  <= '0;
            arr_valid_reg  <= 1'b0;
            arr_idx_reg    <= '0;
            hist_reg       <= '0;
            start_reg      <= '0;
            len_reg        <= '0;
            send_idx_reg   <= '0;
            err_reg        <= rfr_pkg::ST_OVERFLOW;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_status_reg <= rfr_pkg::ST_FRAME;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            ppr_reg        <= ppr_next;
            tail_reg       <= tail_next;
            scan_addr_reg  <= scan_addr_next;
            arr_valid_reg  <= arr_valid_next;
            arr_idx_reg    <= arr_idx_next;
            hist_reg       <= hist_next;
            start_reg      <= start_next;
            len_reg        <= len_next;
            send_idx_reg   <= send_idx_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = out_status_reg;
    assign last      = out_last_reg;

endmodule

// ===== design/resyncing_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resyncing_frame_receiver
// byte window receiver that finds FE EF ... 55 0D 0A frames and checks them
// ----------------------------------------------------------------------------
// a byte is taken, the next cycle checks fill and trailer; with no trailer the
//   block is ready again, or reports an overflow when the window is full
// with a trailer the header scan streams the window memory one byte a cycle;
//   a frame then takes a checksum read and check, then a read and a load per byte
// scan and send are bound by the single read port of the window memory
// reset: fill count, parity and control clear at once; memories read below fill
// ----------------------------------------------------------------------------
module resyncing_frame_receiver #(
    parameter int WINDOW_BYTES = rfr_pkg::WINDOW_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       last
);

    // window index and fill count widths
    localparam int IDX_W = $clog2(WINDOW_BYTES);
    localparam int CNT_W = $clog2(WINDOW_BYTES + 1);

    // window memory port signals
    logic             win_we;
    logic [IDX_W-1:0] win_waddr;
    logic [7:0]       win_wdata;
    logic             win_re;
    logic [IDX_W-1:0] win_raddr;
    logic [7:0]       win_rdata;

    // prefix parity memory: entry k is the xor of the first k held bytes
    logic             pp_we;
    logic [CNT_W-1:0] pp_waddr;
    logic [7:0]       pp_wdata;
    logic             pp_re;
    logic [CNT_W-1:0] pp_raddr;
    logic [7:0]       pp_rdata;

    // received bytes, in arrival order since the last clear
    rfr_ram #(
        .DEPTH (WINDOW_BYTES),
        .AW    (IDX_W)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .re    (win_re),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // one entry more than the window so the full prefix can be held
    rfr_ram #(
        .DEPTH (WINDOW_BYTES + 1),
        .AW    (CNT_W)
    ) u_pp_ram (
        .clk   (clk),
        .we    (pp_we),
        .waddr (pp_waddr),
        .wdata (pp_wdata),
        .re    (pp_re),
        .raddr (pp_raddr),
        .rdata (pp_rdata)
    );

    // sequencer: append, trailer check, header scan, checksum, send
    rfr_ctrl #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last),
        .win_we    (win_we),
        .win_waddr (win_waddr),
        .win_wdata (win_wdata),
        .win_re    (win_re),
        .win_raddr (win_raddr),
        .win_rdata (win_rdata),
        .pp_we     (pp_we),
        .pp_waddr  (pp_waddr),
        .pp_wdata  (pp_wdata),
        .pp_re     (pp_re),
        .pp_raddr  (pp_raddr),
        .pp_rdata  (pp_rdata)
    );

endmodule

// ===== design/rfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_checker
// port-level checks for the resyncing frame receiver
// ----------------------------------------------------------------------------
module rfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] status,
    input logic       last
);

    logic mid_frame_reg;

    // set inside a frame run, after its first item has gone out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_frame_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            mid_frame_reg <= !last;
        end
    end

    // every accepted byte is evaluated before the next one is taken
    a_one_byte_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // error results are single items with a zero byte
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != 2'(rfr_pkg::ST_FRAME)) |-> last && (out_byte == 8'h00))
        else $error("error item without last or with nonzero byte");

    // a frame run opens with the first sync byte and is never cut by an error
    a_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mid_frame_reg && (status == 2'(rfr_pkg::ST_FRAME))
        |-> out_byte == rfr_pkg::SYNC_FIRST)
        else $error("frame run does not start with sync byte");

    a_no_error_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mid_frame_reg |-> status == 2'(rfr_pkg::ST_FRAME))
        else $error("error item inside a frame run");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
        && $stable(last))
        else $error("output item changed while stalled");

endmodule

bind resyncing_frame_receiver rfr_checker u_rfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
);

// ===== tb/sv/rfr_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_frame_checker
// watches both channels of the resyncing frame receiver, predicts the frame
// bytes and error items for every accepted rx byte and compares them in order
// ----------------------------------------------------------------------------
module rfr_frame_checker #(
    parameter int WINDOW_BYTES = rfr_pkg::WINDOW_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic [1:0]  status,
    input  logic        last,
    output int unsigned fail_count,
    output int unsigned results_pending,
    output int unsigned bytes_held
);

    typedef struct packed {
        logic [7:0]       data;
        rfr_pkg::status_t code;
        logic             fin;
    } rx_result_t;

    rx_result_t  results_due[$];
    logic [7:0]  window_bytes[WINDOW_BYTES];
    int unsigned window_fill;
    int unsigned mismatches;

    // add one byte to the window, then look for the frame with the lowest start
    task automatic absorb_rx_byte(input logic [7:0] b);
        int unsigned total;
        int unsigned stop;
        logic [7:0]  parity;
        bit          found;
        found = 1'b0;
        if (window_fill < WINDOW_BYTES)
        begin
            window_bytes[window_fill] = b;
            window_fill++;
        end
        for (int unsigned s = 0; s + rfr_pkg::MIN_TOTAL <= window_fill && !found; s++)
        begin
            if (window_bytes[s] == rfr_pkg::SYNC_FIRST &&
                window_bytes[s + 1] == rfr_pkg::SYNC_SECOND)
            begin
                total = int'(window_bytes[s + rfr_pkg::LEN_POS]) + rfr_pkg::LEN_EXTRA;
                if (total >= rfr_pkg::MIN_TOTAL && s + total <= window_fill)
                begin
                    stop = s + total;
                    if (window_bytes[stop - 3] == rfr_pkg::TAIL_FIRST &&
                        window_bytes[stop - 2] == rfr_pkg::TAIL_SECOND &&
                        window_bytes[stop - 1] == rfr_pkg::TAIL_THIRD)
                    begin
                        found = 1'b1;
                        parity = '0;
                        for (int unsigned k = s + rfr_pkg::SUM_START; k < stop - 4; k++)
                            parity ^= window_bytes[k];
                        if (parity != window_bytes[stop - 4])
                            results_due.push_back('{8'h00, rfr_pkg::ST_CHECKSUM, 1'b1});
                        else
                            for (int unsigned k = 0; k < total; k++)
                                results_due.push_back('{window_bytes[s + k],
                                                        rfr_pkg::ST_FRAME,
                                                        k + 1 == total});
                        window_fill = 0;
                    end
                end
            end
        end
        if (!found && window_fill >= WINDOW_BYTES)
        begin
            results_due.push_back('{8'h00, rfr_pkg::ST_OVERFLOW, 1'b1});
            window_fill = 0;
        end
    endtask

    always @(posedge clk)
    begin
        rx_result_t r;
        if (rst_n)
        begin
            // results first: an item taken at this edge cannot show up yet
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected item: out_byte %02h status %0d last %0b",
                           out_byte, status, last);
                    mismatches++;
                end
                else
                begin
                    r = results_due.pop_front();
                    if (out_byte !== r.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", r.data, out_byte);
                        mismatches++;
                    end
                    if (status !== r.code)
                    begin
                        $error("status: expected %0d, got %0d", r.code, status);
                        mismatches++;
                    end
                    if (last !== r.fin)
                    begin
                        $error("last: expected %0b, got %0b", r.fin, last);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                absorb_rx_byte(rx_byte);
        end
        fail_count      <= mismatches;
        results_pending <= results_due.size();
        bytes_held      <= window_fill;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the resyncing frame receiver: directed frames,
// then random well-formed, corrupted, nested and noise sequences under
// changing idle patterns on both channels; checking lives in the checker
// ----------------------------------------------------------------------------
module tb;

    localparam int WINDOW    = rfr_pkg::WINDOW_BYTES_DEF;
    localparam int LONG_HOLD = 400;

    typedef logic [7:0] octets_t[$];

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic        last;

    int unsigned fail_count;
    int unsigned results_pending;
    int unsigned bytes_held;

    // idle chances in percent, set per phase by the stimulus process
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    // one long receiver hold-off, served once by the receiver process
    bit          long_hold;
    bit          hold_served;

    resyncing_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

    rfr_frame_checker u_frame_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .status          (status),
        .last            (last),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .bytes_held      (bytes_held)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #10ms;
        $display("resyncing_frame_receiver verification failed");
        $finish;
    end

    // receiver side: random stalls, plus one long hold-off that lets the
    // block back up into its input while the sender keeps offering items
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_served)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_served = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one rx byte and hold it until taken; returns on the accept edge
    // with valid still high, so the next call can go on without a bubble
    task automatic put_byte(input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic put_octets(input octets_t f);
        foreach (f[k])
            put_byte(f[k]);
    endtask

    // sender pause until every predicted item has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_pending != 0);
    endtask

    // zeros can never finish a frame, so they empty the window through an
    // overflow at the latest
    task automatic empty_window();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_held != 0)
        begin
            put_byte(8'h00);
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // header, length byte, random body, xor checksum and trailer
    function automatic void build_frame(input int unsigned total, input bit good_sum,
                                        ref octets_t f);
        logic [7:0] sum;
        f.delete();
        f.push_back(rfr_pkg::SYNC_FIRST);
        f.push_back(rfr_pkg::SYNC_SECOND);
        f.push_back(8'($urandom));
        f.push_back(8'(total - rfr_pkg::LEN_EXTRA));
        f.push_back(8'($urandom));
        f.push_back(8'($urandom));
        sum = '0;
        for (int unsigned k = rfr_pkg::SUM_START; k < total - rfr_pkg::LEN_EXTRA; k++)
        begin
            f.push_back(8'($urandom));
            sum ^= f[k];
        end
        if (!good_sum)
            sum ^= 8'($urandom_range(1, 255));
        f.push_back(sum);
        f.push_back(rfr_pkg::TAIL_FIRST);
        f.push_back(rfr_pkg::TAIL_SECOND);
        f.push_back(rfr_pkg::TAIL_THIRD);
    endfunction

    // one random sequence; most are well-formed frames with random content
    task automatic random_sequence();
        octets_t     f;
        octets_t     inner;
        int unsigned kind;
        int unsigned total;
        int unsigned inner_len;
        logic [7:0]  sum;
        logic [7:0]  b;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            // good frame after a little line noise
            repeat ($urandom_range(0, 5)) put_byte(8'($urandom));
            build_frame(rfr_pkg::MIN_TOTAL + $urandom_range(0, 12), 1'b1, f);
            put_octets(f);
        end
        else if (kind < 45)
        begin
            // checksum mismatch
            build_frame(rfr_pkg::MIN_TOTAL + $urandom_range(0, 17), 1'b0, f);
            put_octets(f);
        end
        else if (kind < 55)
        begin
            // header with a length that is too short or can never fit, then resync
            if ($urandom_range(1))
                b = 8'($urandom_range(0, rfr_pkg::MIN_LEN_BYTE - 1));
            else
                b = 8'($urandom_range(WINDOW - rfr_pkg::LEN_EXTRA + 1, 255));
            put_octets('{rfr_pkg::SYNC_FIRST, rfr_pkg::SYNC_SECOND, 8'($urandom), b,
                         8'($urandom)});
            build_frame(rfr_pkg::MIN_TOTAL + $urandom_range(0, 10), 1'b1, f);
            put_octets(f);
        end
        else if (kind < 65)
        begin
            // inner frame at the tail of an outer one: both end on the same
            // byte and the outer, lower start wins
            inner_len = rfr_pkg::MIN_TOTAL + $urandom_range(0, 7);
            build_frame(inner_len, $urandom_range(1), inner);
            total = inner_len + 7 + $urandom_range(0, WINDOW - inner_len - 7);
            f = '{rfr_pkg::SYNC_FIRST, rfr_pkg::SYNC_SECOND, 8'($urandom),
                  8'(total - rfr_pkg::LEN_EXTRA), 8'($urandom), 8'($urandom)};
            while (f.size() < total - inner_len)
                f.push_back(8'($urandom));
            f = {f, inner};
            sum = '0;
            for (int unsigned k = rfr_pkg::SUM_START; k < total - rfr_pkg::LEN_EXTRA; k++)
                sum ^= f[k];
            // usually fix the outer checksum through its first body byte
            if ($urandom_range(3) != 0)
                f[rfr_pkg::SUM_START] ^= sum ^ f[total - rfr_pkg::LEN_EXTRA];
            put_octets(f);
        end
        else if (kind < 72)
        begin
            // frame whose last byte fills the window exactly
            empty_window();
            total = ($urandom_range(3) == 0) ? WINDOW
                                             : rfr_pkg::MIN_TOTAL + $urandom_range(0, 20);
            repeat (WINDOW - total)
            begin
                b = 8'($urandom);
                put_byte((b == rfr_pkg::SYNC_FIRST) ? 8'h00 : b);
            end
            build_frame(total, $urandom_range(3) != 0, f);
            put_octets(f);
        end
        else if (kind < 80)
        begin
            // longest frames from an empty window
            empty_window();
            build_frame(WINDOW - $urandom_range(0, 4), 1'b1, f);
            put_octets(f);
        end
        else if (kind < 90)
        begin
            // plain noise, overflows now and then
            repeat ($urandom_range(8, 40)) put_byte(8'($urandom));
        end
        else
        begin
            // frame with a damaged or missing trailer byte
            build_frame(rfr_pkg::MIN_TOTAL + $urandom_range(0, 12), 1'b1, f);
            if ($urandom_range(1))
                f[f.size() - 1 - $urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
            else
                void'(f.pop_back());
            put_octets(f);
        end
    endtask

    initial
    begin
        octets_t f;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        rst_n         = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent    = 0;
        long_hold     = 1'b0;
        hold_served   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // shortest good frame with all-zero and all-one fields
        f = '{rfr_pkg::SYNC_FIRST, rfr_pkg::SYNC_SECOND, 8'h00, 8'(rfr_pkg::MIN_LEN_BYTE),
              8'hFF, 8'h00, 8'h00, 8'hFF, 8'h5A, 8'hA5,
              rfr_pkg::TAIL_FIRST, rfr_pkg::TAIL_SECOND, rfr_pkg::TAIL_THIRD};
        put_octets(f);
        // shortest frame with a wrong checksum
        f = '{rfr_pkg::SYNC_FIRST, rfr_pkg::SYNC_SECOND, 8'hFF, 8'(rfr_pkg::MIN_LEN_BYTE),
              8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h00,
              rfr_pkg::TAIL_FIRST, rfr_pkg::TAIL_SECOND, rfr_pkg::TAIL_THIRD};
        put_octets(f);
        wait_drained();

        // three idle phases: sender light and receiver heavy, the reverse,
        // then none, with the long receiver hold-off at the start of the last
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    long_hold     = 1'b1;
                end
            endcase
            while (items_sent < 26 + (phase + 1) * 148)
                random_sequence();
            wait_drained();
        end

        // let any scan still running finish before the verdict
        repeat (300) @(posedge clk);
        if (fail_count == 0 && results_pending == 0)
            $display("resyncing_frame_receiver verification clean");
        else
            $display("resyncing_frame_receiver verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/rfr_pkg.sv
design/rfr_ram.sv
design/rfr_ctrl.sv
design/resyncing_frame_receiver.sv
design/rfr_checker.sv
tb/sv/rfr_frame_checker.sv
tb/sv/tb.sv
